>>> rtl/mmpq_pkg.sv
// Shared types and constants for the min/max priority queue.
// Used by mmpq_front, mmpq_back and min_max_priority_queue; depends on nothing.
package mmpq_pkg;

   localparam int DEPTH       = 8;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int SUM_W       = IDX_W + 1;
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH     = 3'd0,
      KIND_POP_MAX  = 3'd1,
      KIND_POP_MIN  = 3'd2,
      KIND_PEEK_MAX = 3'd3,
      KIND_PEEK_MIN = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_PUSH,
      OP_POP,
      OP_PEEK
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic                      want_max;
      logic signed [DATA_W-1:0]  data;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESP
   } state_type;

endpackage

>>> rtl/min_max_priority_queue.sv
// Top level of the double-ended min/max priority queue.
// Depends on mmpq_pkg, mmpq_front and mmpq_back.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/stall    req_kind, req_data_in
//   rsp_      out        rsp_valid/stall    rsp_value_out, rsp_status, rsp_occupancy
//
// With an idle back end, a push, an error or an unused kind passes from S_IDLE
// to S_RESP, and its response is registered on leaving S_RESP. A pop or peek
// first scans each live entry in S_SCAN_RD and S_SCAN_CMP; a pop then moves
// each shifted entry in S_SHIFT_RD and S_SHIFT_WR, as the entry store has a
// single read port. Reset is synchronous and active high; the entry store is
// not cleared. Two decoded requests can wait ahead of the back end, so
// req_stall rises only when both slots are taken; the response register frees
// the back end unless rsp_stall holds it.
module min_max_priority_queue import mmpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [DATA_W-1:0] req_data_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_value_out,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   mmpq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_data_in (req_data_in),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   mmpq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

>>> rtl/mmpq_front.sv
// Front end: accepts requests, decodes them into commands and buffers them
// in a two-entry queue for the back end. Depends on mmpq_pkg.
module mmpq_front import mmpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [DATA_W-1:0] req_data_in,
   output logic                     cmd_valid,
   output cmd_type                  cmd,
   input  logic                     cmd_take
);

   cmd_type             decoded;
   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   always_comb begin
      decoded.data     = req_data_in;
      decoded.want_max = 1'b0;
      case (req_kind)
         KIND_PUSH:     decoded.op = OP_PUSH;
         KIND_POP_MAX: begin
            decoded.op       = OP_POP;
            decoded.want_max = 1'b1;
         end
         KIND_POP_MIN:  decoded.op = OP_POP;
         KIND_PEEK_MAX: begin
            decoded.op       = OP_PEEK;
            decoded.want_max = 1'b1;
         end
         KIND_PEEK_MIN: decoded.op = OP_PEEK;
         default:       decoded.op = OP_NOP;
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_valid && cmd_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> rtl/mmpq_back.sv
// Back end: holds the circular entry store, scans for the extreme value,
// closes the gap after a pop and registers the response. Depends on mmpq_pkg.
module mmpq_back import mmpq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  cmd_type                  cmd,
   output logic                     cmd_take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_value_out,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   // Slot that lies off places after the head, with head plus off below twice the depth.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   cmd_type                  cur_ff, cur_in;
   logic [CNT_W-1:0]         off_ff, off_in;
   logic [CNT_W-1:0]         best_off_ff, best_off_in;
   logic signed [DATA_W-1:0] best_val_ff, best_val_in;
   logic signed [DATA_W-1:0] res_value_ff, res_value_in;
   status_type               res_status_ff, res_status_in;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [OCC_W-1:0]         rsp_occ_ff;

   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic signed [DATA_W-1:0] mem_wdata;
   logic [IDX_W-1:0]         rd_addr;
   logic                     better;
   logic                     scan_last;
   logic                     out_free;
   logic                     load_rsp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign better    = (off_ff == '0) ||
                      (cur_ff.want_max ? (rd_data_ff > best_val_ff)
                                       : (rd_data_ff < best_val_ff));
   assign scan_last = ((off_ff + CNT_W'(1)) == count_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if ((cmd.op == OP_POP || cmd.op == OP_PEEK) && count_ff != '0) begin
                  state_in = S_SCAN_RD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN_RD:  state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (!scan_last) begin
               state_in = S_SCAN_RD;
            end else if (cur_ff.op == OP_POP && best_off_in != '0) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = (off_ff == CNT_W'(1)) ? S_RESP : S_SHIFT_RD;
         S_RESP:     state_in = out_free ? S_IDLE : S_RESP;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      cmd_take      = 1'b0;
      load_rsp      = 1'b0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      off_in        = off_ff;
      best_off_in   = best_off_ff;
      best_val_in   = best_val_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = tail_ff;
      mem_wdata     = cmd.data;
      rd_addr       = slot_of(head_ff, off_ff);
      case (state_ff)
         S_IDLE: begin
            cmd_take = cmd_valid;
            if (cmd_valid) begin
               cur_in        = cmd;
               off_in        = '0;
               res_value_in  = '0;
               res_status_in = ST_OK;
               if (cmd.op == OP_PUSH) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     tail_in  = next_slot(tail_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if ((cmd.op == OP_POP || cmd.op == OP_PEEK) && count_ff == '0) begin
                  res_status_in = ST_EMPTY;
               end
            end
         end
         S_SCAN_RD: begin
            rd_addr = slot_of(head_ff, off_ff);
         end
         S_SCAN_CMP: begin
            if (better) begin
               best_val_in = rd_data_ff;
               best_off_in = off_ff;
            end
            if (!scan_last) begin
               off_in = off_ff + CNT_W'(1);
            end else begin
               res_value_in = better ? rd_data_ff : best_val_ff;
               if (cur_ff.op == OP_POP) begin
                  if (best_off_in != '0) begin
                     off_in = best_off_in;
                  end else begin
                     head_in  = next_slot(head_ff);
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         S_SHIFT_RD: begin
            rd_addr = slot_of(head_ff, off_ff - CNT_W'(1));
         end
         S_SHIFT_WR: begin
            // Older entry moves one slot toward the tail over the removed one.
            mem_we    = 1'b1;
            mem_waddr = slot_of(head_ff, off_ff);
            mem_wdata = rd_data_ff;
            off_in    = off_ff - CNT_W'(1);
            if (off_ff == CNT_W'(1)) begin
               head_in  = next_slot(head_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end
         S_RESP: begin
            load_rsp = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      off_ff        <= off_in;
      best_off_ff   <= best_off_in;
      best_val_ff   <= best_val_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (load_rsp) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
         rsp_occ_ff    <= OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      tail_ff == slot_of(head_ff, count_ff))
      else $error("tail does not match head plus count");

   a_shift_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_RD || state_ff == S_SHIFT_WR) |-> off_ff != '0)
      else $error("shift with zero offset");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_RD || state_ff == S_SCAN_CMP) |-> count_ff != '0)
      else $error("scan of an empty queue");

endmodule

>>> test/testbench.sv
// Self-checking testbench for min_max_priority_queue: directed and random requests.
// A built-in queue predictor supplies the expected reply for each accepted request.
// Depends on mmpq_pkg and the min_max_priority_queue RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mmpq_pkg::*;

   localparam int CYCLE_LIMIT   = 250000;
   localparam int DRAIN_CYCLES  = 64;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 160;

   localparam logic [KIND_W-1:0]        KIND_FIRST_UNUSED = 3'd5;
   localparam logic [KIND_W-1:0]        KIND_LAST_UNUSED  = 3'd7;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } reply_type;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind    = '0;
   logic signed [DATA_W-1:0] req_data_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   logic signed [DATA_W-1:0] rsp_value_out;
   logic [STATUS_W-1:0]      rsp_status;
   logic [OCC_W-1:0]         rsp_occupancy;

   // Predictor state: the live entries in arrival order around a ring.
   logic signed [DATA_W-1:0] model_slots [DEPTH];
   int model_head  = 0;
   int model_tail  = 0;
   int model_count = 0;

   reply_type expected_replies [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int stall_hold_left    = 0;
   int cycle_count        = 0;
   int error_count        = 0;
   int requests_sent      = 0;
   int replies_checked    = 0;
   int full_refusals      = 0;
   int empty_refusals     = 0;
   int unused_kinds       = 0;

   min_max_priority_queue u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Applies one request to the predictor and returns the reply it must produce.
   function automatic reply_type predict_reply(input logic [KIND_W-1:0] kind,
                                               input logic signed [DATA_W-1:0] data);
      reply_type                reply;
      int                       best_off;
      logic signed [DATA_W-1:0] best_val;
      logic signed [DATA_W-1:0] cur_val;
      logic                     want_max;
      reply.value  = '0;
      reply.status = ST_OK;
      if (kind == KIND_PUSH) begin
         if (model_count >= DEPTH) begin
            reply.status = ST_FULL;
            full_refusals++;
         end else begin
            model_slots[model_tail] = data;
            model_tail = (model_tail + 1) % DEPTH;
            model_count++;
         end
      end else if (kind >= KIND_POP_MAX && kind <= KIND_PEEK_MIN) begin
         if (model_count == 0) begin
            reply.status = ST_EMPTY;
            empty_refusals++;
         end else begin
            want_max = (kind == KIND_POP_MAX || kind == KIND_PEEK_MAX);
            best_off = 0;
            best_val = model_slots[model_head];
            // Strict comparison keeps the oldest of equal values.
            for (int k = 1; k < model_count; k++) begin
               cur_val = model_slots[(model_head + k) % DEPTH];
               if (want_max ? (cur_val > best_val) : (cur_val < best_val)) begin
                  best_val = cur_val;
                  best_off = k;
               end
            end
            reply.value = best_val;
            if (kind == KIND_POP_MAX || kind == KIND_POP_MIN) begin
               for (int k = best_off; k > 0; k--)
                  model_slots[(model_head + k) % DEPTH] =
                     model_slots[(model_head + k - 1) % DEPTH];
               model_head = (model_head + 1) % DEPTH;
               model_count--;
            end
         end
      end else begin
         unused_kinds++;
      end
      reply.occupancy = OCC_W'(model_count);
      return reply;
   endfunction

   // Offers one transaction after a random gap and waits until it is taken.
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic signed [DATA_W-1:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_data_in <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_replies.push_back(predict_reply(kind, data));
      requests_sent++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $signed(DATA_W'($urandom_range(8))) - 4;  // Narrow range for ties.
         1: begin
            case ($urandom_range(3))
               0: return VALUE_MAX;
               1: return VALUE_MIN;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic note_mismatch(input string field, input longint want, input longint got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
   endtask

   // Receiver: random stalls, or a long hold-off while stall_hold_left runs down.
   always @(posedge clock) begin
      if (stall_hold_left > 0) begin
         rsp_stall <= 1'b1;
         stall_hold_left <= stall_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : check_replies
      reply_type want;
      if (!reset && $isunknown(rsp_valid)) begin
         error_count++;
         $display("%0t: rsp_valid is unknown", $realtime);
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            error_count++;
            $display("%0t: reply with nothing outstanding, value %0d status %0d count %0d",
                     $realtime, rsp_value_out, rsp_status, rsp_occupancy);
         end else begin
            want = expected_replies.pop_front();
            replies_checked++;
            if (rsp_value_out !== want.value)
               note_mismatch("value_out", want.value, rsp_value_out);
            if (rsp_status !== want.status)
               note_mismatch("status", want.status, rsp_status);
            if (rsp_occupancy !== want.occupancy)
               note_mismatch("occupancy", want.occupancy, rsp_occupancy);
         end
      end
   end

   task automatic test_empty_queue();
      send_request(KIND_POP_MAX, 32'sd17);
      send_request(KIND_POP_MIN, VALUE_MIN);
      send_request(KIND_PEEK_MAX, VALUE_MAX);
      send_request(KIND_PEEK_MIN, -1);
      for (logic [KIND_W-1:0] k = KIND_FIRST_UNUSED; k <= KIND_LAST_UNUSED; k++) begin
         send_request(k, $urandom);
         if (k == KIND_LAST_UNUSED)
            break;
      end
   endtask

   // Fills to capacity with extremes and repeated values, then drains by pops.
   task automatic test_fill_and_drain();
      send_request(KIND_PUSH, VALUE_MAX);
      send_request(KIND_PUSH, VALUE_MIN);
      send_request(KIND_PUSH, '0);
      send_request(KIND_PUSH, -1);
      send_request(KIND_FIRST_UNUSED, VALUE_MAX);
      send_request(KIND_PUSH, 32'sd1);
      send_request(KIND_PUSH, VALUE_MAX);
      send_request(KIND_PUSH, VALUE_MIN);
      send_request(KIND_PUSH, '0);
      send_request(KIND_PUSH, 32'sd42);
      send_request(KIND_PEEK_MAX, '0);
      send_request(KIND_PEEK_MIN, '0);
      send_request(KIND_POP_MAX, '0);
      send_request(KIND_POP_MIN, '0);
      send_request(KIND_POP_MIN, '0);
      send_request(KIND_POP_MAX, '0);
      send_request(KIND_POP_MIN, '0);
      send_request(KIND_POP_MAX, '0);
      send_request(KIND_POP_MIN, '0);
      send_request(KIND_POP_MAX, '0);
   endtask

   // Runs of push-heavy and pop-heavy traffic so the queue swings between full and empty.
   task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
      int                  push_pct;
      int                  pick;
      logic [KIND_W-1:0]   kind;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      push_pct = 50;
      for (int n = 0; n < items; n++) begin
         if (n % 16 == 0)
            push_pct = $urandom_range(85, 25);
         pick = $urandom_range(99);
         if (pick < 3) begin
            kind = KIND_FIRST_UNUSED + KIND_W'($urandom_range(2));
         end else if (pick < push_pct) begin
            kind = KIND_PUSH;
         end else begin
            case ($urandom_range(9))
               0, 1, 2: kind = KIND_POP_MAX;
               3, 4, 5: kind = KIND_POP_MIN;
               6, 7:    kind = KIND_PEEK_MAX;
               default: kind = KIND_PEEK_MIN;
            endcase
         end
         send_request(kind, pick_value());
      end
   endtask

   // The receiver holds off while the sender keeps offering, so the input must stall.
   task automatic test_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      stall_hold_left    = HOLD_CYCLES;
      for (int n = 0; n < 14; n++)
         send_request((n % 3 == 2) ? KIND_PEEK_MIN : KIND_PUSH, pick_value());
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: errors");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_fill_and_drain();
      test_random_traffic(PHASE_ITEMS, 0, 0);
      test_backpressure();
      test_random_traffic(PHASE_ITEMS, 60, 0);
      test_random_traffic(PHASE_ITEMS, 0, 60);
      test_random_traffic(PHASE_ITEMS, 20, 20);

      req_valid <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d replies in %0d cycles.",
               requests_sent, replies_checked, cycle_count);
      $display("Refused pushes when full: %0d, empty pops/peeks: %0d, unused kinds: %0d.",
               full_refusals, empty_refusals, unused_kinds);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
